FILE: hdl/uvs_pkg.sv
`timescale 1ns / 1ps

package uvs_pkg;

    // Input index width and angle word width
    localparam int KW        = 8;
    localparam int ANGLE_W   = 32;
    // Full quotient of (k << 32) / d
    localparam int QUO_W     = KW + ANGLE_W;
    // Long division: quotient bits resolved per pipeline stage
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = QUO_W / DIV_STEPS;

    // CORDIC datapath width (Q2.30 plus headroom)
    localparam int CW = 34;

    localparam logic [31:0] PI_Q30           = 32'd3373259426;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_RADIUS   = 3'd0;
    localparam logic [2:0] REG_CENTER_X = 3'd1;
    localparam logic [2:0] REG_CENTER_Y = 3'd2;
    localparam logic [2:0] REG_CENTER_Z = 3'd3;
    localparam logic [2:0] REG_SEGMENTS = 3'd4;
    localparam logic [2:0] REG_BASE     = 3'd5;

    // Per-vertex side data that travels beside the trigonometry
    typedef struct packed {
        logic [23:0] index;
        logic        quad;
        logic [16:0] u;
        logic [16:0] v;
    } side_t;

    // Arctangent of 2^-i in Q2.30, truncated
    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
        logic signed [CW-1:0] a;
        case (i)
            5'd0:  a = 34'sd843314856;
            5'd1:  a = 34'sd497837829;
            5'd2:  a = 34'sd263043836;
            5'd3:  a = 34'sd133525158;
            5'd4:  a = 34'sd67021686;
            5'd5:  a = 34'sd33543515;
            5'd6:  a = 34'sd16775850;
            5'd7:  a = 34'sd8388437;
            5'd8:  a = 34'sd4194282;
            5'd9:  a = 34'sd2097149;
            5'd10: a = 34'sd1048575;
            5'd11: a = 34'sd524287;
            5'd12: a = 34'sd262143;
            5'd13: a = 34'sd131071;
            5'd14: a = 34'sd65535;
            5'd15: a = 34'sd32767;
            5'd16: a = 34'sd16383;
            5'd17: a = 34'sd8191;
            5'd18: a = 34'sd4095;
            5'd19: a = 34'sd2047;
            5'd20: a = 34'sd1023;
            5'd21: a = 34'sd511;
            5'd22: a = 34'sd255;
            5'd23: a = 34'sd127;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

FILE: hdl/uvs_divider.sv
`timescale 1ns / 1ps

// Pipelined restoring divider: q = (k << 32) / d, a few quotient bits per stage
module uvs_divider #(
    parameter int DW = 9
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic [uvs_pkg::KW-1:0]  k,
    input  logic [DW-1:0]           d,
    output logic [uvs_pkg::QUO_W-1:0] q
);

    localparam int QW = uvs_pkg::QUO_W;
    localparam int NS = uvs_pkg::DIV_STAGES;

    logic [DW-1:0] rem_reg  [NS];
    logic [QW-1:0] quo_reg  [NS];
    logic [QW-1:0] dvd_reg  [NS];
    logic [DW-1:0] rem_in   [NS];
    logic [QW-1:0] quo_in   [NS];
    logic [QW-1:0] dvd_in   [NS];
    logic [DW-1:0] rem_next [NS];
    logic [QW-1:0] quo_next [NS];
    logic [QW-1:0] dvd_next [NS];

    for (genvar g = 0; g < NS; g++) begin : g_stage
        // Feed the first stage from the port, the rest from the stage before
        if (g == 0) begin : g_first
            assign rem_in[g] = '0;
            assign quo_in[g] = '0;
            assign dvd_in[g] = {k, {uvs_pkg::ANGLE_W{1'b0}}};
        end else begin : g_rest
            assign rem_in[g] = rem_reg[g-1];
            assign quo_in[g] = quo_reg[g-1];
            assign dvd_in[g] = dvd_reg[g-1];
        end

        // Resolve the quotient bits of this stage
        always_comb
        begin
            logic [DW-1:0] rem;
            logic [QW-1:0] quo;
            logic [QW-1:0] dvd;
            logic [DW:0]   trial;
            rem = rem_in[g];
            quo = quo_in[g];
            dvd = dvd_in[g];
            for (int j = 0; j < uvs_pkg::DIV_STEPS; j++)
            begin
                trial = {rem, dvd[QW-1]};
                dvd   = {dvd[QW-2:0], 1'b0};
                if (trial >= {1'b0, d})
                begin
                    trial = trial - {1'b0, d};
                    quo   = {quo[QW-2:0], 1'b1};
                end
                else
                begin
                    quo   = {quo[QW-2:0], 1'b0};
                end
                rem = trial[DW-1:0];
            end
            rem_next[g] = rem;
            quo_next[g] = quo;
            dvd_next[g] = dvd;
        end

        // Advance the stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g] <= rem_next[g];
                quo_reg[g] <= quo_next[g];
                dvd_reg[g] <= dvd_next[g];
            end
        end
    end

    assign q = quo_reg[NS-1];

endmodule

FILE: hdl/uvs_cordic.sv
`timescale 1ns / 1ps

// Rotation-mode CORDIC, one micro-rotation per pipeline stage
module uvs_cordic #(
    parameter int STEPS = 16
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [uvs_pkg::CW-1:0]    z_in,
    input  logic [1:0]                       quad_in,
    output logic signed [uvs_pkg::CW-1:0]    x_out,
    output logic signed [uvs_pkg::CW-1:0]    y_out,
    output logic [1:0]                       quad_out
);

    localparam int CW = uvs_pkg::CW;

    logic signed [CW-1:0] x_reg [STEPS];
    logic signed [CW-1:0] y_reg [STEPS];
    logic signed [CW-1:0] z_reg [STEPS];
    logic [1:0]           q_reg [STEPS];
    logic signed [CW-1:0] x_in  [STEPS];
    logic signed [CW-1:0] y_in  [STEPS];
    logic signed [CW-1:0] z_st  [STEPS];
    logic [1:0]           q_in  [STEPS];

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        if (g == 0) begin : g_first
            assign x_in[g] = uvs_pkg::CORDIC_GAIN;
            assign y_in[g] = '0;
            assign z_st[g] = z_in;
            assign q_in[g] = quad_in;
        end else begin : g_rest
            assign x_in[g] = x_reg[g-1];
            assign y_in[g] = y_reg[g-1];
            assign z_st[g] = z_reg[g-1];
            assign q_in[g] = q_reg[g-1];
        end

        // Rotate towards zero residual angle
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_st[g][CW-1])
                begin
                    x_reg[g] <= x_in[g] - (y_in[g] >>> g);
                    y_reg[g] <= y_in[g] + (x_in[g] >>> g);
                    z_reg[g] <= z_st[g] - uvs_pkg::atan_q30(5'(g));
                end
                else
                begin
                    x_reg[g] <= x_in[g] + (y_in[g] >>> g);
                    y_reg[g] <= y_in[g] - (x_in[g] >>> g);
                    z_reg[g] <= z_st[g] + uvs_pkg::atan_q30(5'(g));
                end
                q_reg[g] <= q_in[g];
            end
        end
    end

    assign x_out    = x_reg[STEPS-1];
    assign y_out    = y_reg[STEPS-1];
    assign quad_out = q_reg[STEPS-1];

endmodule

FILE: hdl/uv_sphere_vertex_generator.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in        sink       in_valid/in_ready    ring_number, sector_number
// out       source     out_valid/out_ready  pos, normal, tex, vertex_index, quad_follows
// cfg       sink       cfg_we               cfg_index, cfg_data
//
// One vertex per cycle sustained while the output is not stalled; the pipeline depth is set by the
// ten-stage angle divider and one CORDIC stage per micro-rotation.
// Reset clears only the valid bits and sets the configuration registers to their defaults.
// A stall at the output freezes the whole pipeline; in_ready follows it.
module uv_sphere_vertex_generator #(
    parameter int MAX_SEGMENTS = 255,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         ring_number,
    input  logic [7:0]         sector_number,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [20:0] pos_x,
    output logic signed [20:0] pos_y,
    output logic signed [20:0] pos_z,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic signed [15:0] normal_z,
    output logic [16:0]        tex_u,
    output logic [16:0]        tex_v,
    output logic [23:0]        vertex_index,
    output logic               quad_follows
);

    localparam int CW    = uvs_pkg::CW;
    localparam int NB    = $clog2(MAX_SEGMENTS + 1);
    localparam int NW    = (NB > 8) ? NB : 8;
    localparam int NS    = uvs_pkg::DIV_STAGES;
    localparam int SIDEB = CORDIC_STEPS + 4;
    localparam int LAT   = NS + CORDIC_STEPS + 6;

    // Configuration registers
    logic [15:0]        radius_reg;
    logic signed [15:0] cx_reg, cy_reg, cz_reg;
    logic [7:0]         seg_reg;
    logic [23:0]        base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 16'd256;
            cx_reg     <= '0;
            cy_reg     <= '0;
            cz_reg     <= '0;
            seg_reg    <= 8'd16;
            base_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                uvs_pkg::REG_RADIUS:   radius_reg <= cfg_data[15:0];
                uvs_pkg::REG_CENTER_X: cx_reg     <= cfg_data[15:0];
                uvs_pkg::REG_CENTER_Y: cy_reg     <= cfg_data[15:0];
                uvs_pkg::REG_CENTER_Z: cz_reg     <= cfg_data[15:0];
                uvs_pkg::REG_SEGMENTS: seg_reg    <= cfg_data[7:0];
                uvs_pkg::REG_BASE:     base_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective segment count: zero reads as one, clip to the maximum
    logic [NW-1:0] seg_ext, n_eff;
    assign seg_ext = NW'(seg_reg);
    always_comb
    begin
        if (seg_ext == '0)
            n_eff = NW'(1);
        else if (seg_ext > NW'(MAX_SEGMENTS))
            n_eff = NW'(MAX_SEGMENTS);
        else
            n_eff = seg_ext;
    end

    // Global pipeline enable and valid line
    logic           en;
    logic [LAT-1:0] vld_reg;
    assign en        = !vld_reg[LAT-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    // Input stage
    logic [7:0] r0_reg, s0_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r0_reg <= ring_number;
            s0_reg <= sector_number;
        end
    end

    // Index and quad flag, held beside the dividers
    uvs_pkg::side_t side0;
    logic [31:0]    idx_sum;
    assign idx_sum = 32'(base_reg) + 32'(r0_reg) * (32'(n_eff) + 32'd1)
                   + 32'(s0_reg);
    always_comb
    begin
        side0.index = idx_sum[23:0];
        side0.quad  = (NW'(r0_reg) < n_eff) && (NW'(s0_reg) < n_eff);
        side0.u     = '0;
        side0.v     = '0;
    end

    uvs_pkg::side_t sidea_reg [NS];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sidea_reg[0] <= side0;
            for (int i = 1; i < NS; i++)
                sidea_reg[i] <= sidea_reg[i-1];
        end
    end

    // Angle dividers: phi over 2n, theta over n
    logic [uvs_pkg::QUO_W-1:0] qp, qs;

    uvs_divider #(.DW(NW + 1)) u_div_phi (
        .clk (clk),
        .en  (en),
        .k   (r0_reg),
        .d   ({n_eff, 1'b0}),
        .q   (qp)
    );

    uvs_divider #(.DW(NW)) u_div_theta (
        .clk (clk),
        .en  (en),
        .k   (s0_reg),
        .d   (n_eff),
        .q   (qs)
    );

    // Split off the quadrant and scale the residual to radians
    function automatic logic signed [CW-1:0] to_radians(input logic [31:0] t);
        logic [31:0] qsum, e;
        logic [30:0] mag;
        logic [62:0] prod;
        logic [CW-1:0] zmag;
        qsum = t + 32'h4000_0000;
        e    = t - {qsum[31:30], 30'd0};
        mag  = e[31] ? 31'(-e) : e[30:0];
        prod = 63'(mag) * 63'(uvs_pkg::PI_Q30);
        zmag = CW'(prod[62:31]);
        return e[31] ? -$signed(zmag) : $signed(zmag);
    endfunction

    function automatic logic [1:0] quad_of(input logic [31:0] t);
        logic [31:0] qsum;
        qsum = t + 32'h4000_0000;
        return qsum[31:30];
    endfunction

    function automatic logic [16:0] tex_sat(input logic [24:0] v);
        return (v > 25'd65536) ? 17'd65536 : v[16:0];
    endfunction

    logic signed [CW-1:0] zp_reg, zs_reg;
    logic [1:0]           qp_reg, qs_reg;
    uvs_pkg::side_t       sideb_reg [SIDEB];
    uvs_pkg::side_t       sidea_last;

    always_comb
    begin
        sidea_last   = sidea_reg[NS-1];
        sidea_last.u = tex_sat({1'b0, qs[39:16]});
        sidea_last.v = tex_sat(qp[39:15]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zp_reg       <= to_radians(qp[31:0]);
            zs_reg       <= to_radians(qs[31:0]);
            qp_reg       <= quad_of(qp[31:0]);
            qs_reg       <= quad_of(qs[31:0]);
            sideb_reg[0] <= sidea_last;
            for (int i = 1; i < SIDEB; i++)
                sideb_reg[i] <= sideb_reg[i-1];
        end
    end

    // CORDIC lanes
    logic signed [CW-1:0] xp, yp, xs, ys;
    logic [1:0]           qpo, qso;

    uvs_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_phi (
        .clk      (clk),
        .en       (en),
        .z_in     (zp_reg),
        .quad_in  (qp_reg),
        .x_out    (xp),
        .y_out    (yp),
        .quad_out (qpo)
    );

    uvs_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_theta (
        .clk      (clk),
        .en       (en),
        .z_in     (zs_reg),
        .quad_in  (qs_reg),
        .x_out    (xs),
        .y_out    (ys),
        .quad_out (qso)
    );

    // Round Q2.30 to Q1.14 and clamp to one
    function automatic logic signed [15:0] to_q14(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        r = (v + CW'(32768)) >>> 16;
        if (r > CW'(16384))
            return 16'sd16384;
        else if (r < -CW'(16384))
            return -16'sd16384;
        else
            return r[15:0];
    endfunction

    function automatic logic signed [CW-1:0] rot_cos(input logic [1:0] q,
        input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
        case (q)
            2'd0:    return x;
            2'd1:    return -y;
            2'd2:    return -x;
            default: return y;
        endcase
    endfunction

    function automatic logic signed [CW-1:0] rot_sin(input logic [1:0] q,
        input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
        case (q)
            2'd0:    return y;
            2'd1:    return x;
            2'd2:    return -y;
            default: return -x;
        endcase
    endfunction

    // Quadrant rotation and rounding
    logic signed [15:0] sp_reg, cp_reg, st_reg, ct_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sp_reg <= to_q14(rot_sin(qpo, xp, yp));
            cp_reg <= to_q14(rot_cos(qpo, xp, yp));
            st_reg <= to_q14(rot_sin(qso, xs, ys));
            ct_reg <= to_q14(rot_cos(qso, xs, ys));
        end
    end

    // Normal x and y products
    function automatic logic signed [15:0] mul_q14(input logic signed [15:0] a,
        input logic signed [15:0] b);
        logic signed [31:0] p;
        p = ((a * b) + 32'sd8192) >>> 14;
        if (p > 32'sd16384)
            return 16'sd16384;
        else if (p < -32'sd16384)
            return -16'sd16384;
        else
            return p[15:0];
    endfunction

    logic signed [15:0] nx_reg, ny_reg, nz_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg <= mul_q14(sp_reg, ct_reg);
            ny_reg <= mul_q14(sp_reg, st_reg);
            nz_reg <= cp_reg;
        end
    end

    // Scale by the radius
    logic signed [32:0] mx_reg, my_reg, mz_reg;
    logic signed [15:0] nx2_reg, ny2_reg, nz2_reg;
    logic signed [16:0] rad_s;
    assign rad_s = $signed({1'b0, radius_reg});
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg  <= rad_s * nx_reg;
            my_reg  <= rad_s * ny_reg;
            mz_reg  <= rad_s * nz_reg;
            nx2_reg <= nx_reg;
            ny2_reg <= ny_reg;
            nz2_reg <= nz_reg;
        end
    end

    // Add the centre and saturate to Q12.8
    function automatic logic signed [20:0] place(input logic signed [15:0] c,
        input logic signed [32:0] m);
        logic signed [32:0] t;
        logic signed [33:0] p;
        t = (m + 33'sd8192) >>> 14;
        p = 34'(t) + 34'(c);
        if (p > 34'sd1048575)
            return 21'sd1048575;
        else if (p < -34'sd1048576)
            return -21'sd1048576;
        else
            return p[20:0];
    endfunction

    // Output register
    logic signed [20:0] px_reg, py_reg, pz_reg;
    logic signed [15:0] onx_reg, ony_reg, onz_reg;
    uvs_pkg::side_t     oside_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg    <= place(cx_reg, mx_reg);
            py_reg    <= place(cy_reg, my_reg);
            pz_reg    <= place(cz_reg, mz_reg);
            onx_reg   <= nx2_reg;
            ony_reg   <= ny2_reg;
            onz_reg   <= nz2_reg;
            oside_reg <= sideb_reg[SIDEB-1];
        end
    end

    assign pos_x        = px_reg;
    assign pos_y        = py_reg;
    assign pos_z        = pz_reg;
    assign normal_x     = onx_reg;
    assign normal_y     = ony_reg;
    assign normal_z     = onz_reg;
    assign tex_u        = oside_reg.u;
    assign tex_v        = oside_reg.v;
    assign vertex_index = oside_reg.index;
    assign quad_follows = oside_reg.quad;

endmodule
